// File: rtl/lzw_pkg.sv
// shared constants for the lzw encoder
// no dependencies
package lzw_pkg;

   localparam int DICT_ENTRIES_DEF = 4096;
   localparam int FIRST_PAIR_CODE  = 256;
   localparam int CODE_W           = 12;
   localparam int BYTE_W           = 8;
   localparam int EPOCH_W          = 8;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

endpackage

// File: rtl/lzw_encoder_top.sv
// lzw encoder top: byte transactions in, code transactions out; uses lzw_pkg, lzw_core, lzw_ram
// per byte: the first of a stream only loads the prefix; later bytes take a hash table probe,
//   more while live slots mismatch; a miss emits a code; the final byte flushes the last code
// one byte at a time: req_stall holds the next until the current is done, response stalls included
// reset: clear pass over all 2**(clog2(DICT_ENTRIES)+1) slots (8192 by default), repeated
//   after every 255th stream when the slot epoch wraps; no bytes are taken meanwhile
module lzw_encoder_top import lzw_pkg::*; #(
   parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_end_of_stream,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_last_code
);

   localparam int CW     = $clog2(DICT_ENTRIES);
   localparam int IW     = CW + 1;
   localparam int DEPTH  = 2 ** IW;
   localparam int SLOT_W = EPOCH_W + CW + BYTE_W + CW;

   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic [IW-1:0]     ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;

   lzw_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lzw_core #(
      .DICT_ENTRIES (DICT_ENTRIES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code          (rsp_code),
      .rsp_last_code     (rsp_last_code),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

endmodule

// File: rtl/lzw_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lzw_core.sv
// lzw sequencer: hash table probe, dictionary insert, code emission and clear pass
// depends on lzw_pkg; drives the hash table ram ports
module lzw_core import lzw_pkg::*; #(
   parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
   localparam int CW     = $clog2(DICT_ENTRIES),
   localparam int IW     = CW + 1,
   localparam int SLOT_W = EPOCH_W + CW + BYTE_W + CW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_end_of_stream,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_last_code,
   output logic              ram_wr_en,
   output logic [IW-1:0]     ram_wr_addr,
   output logic [SLOT_W-1:0] ram_wr_data,
   output logic [IW-1:0]     ram_rd_addr,
   input  logic [SLOT_W-1:0] ram_rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_EMIT_MISS,
      ST_EMIT_LAST
   } state_type;

   localparam logic [CW:0] NF_FIRST = (CW+1)'(FIRST_PAIR_CODE);
   localparam logic [CW:0] NF_LIMIT = (CW+1)'(DICT_ENTRIES);

   state_type           state_ff, state_in;
   logic [CW-1:0]       pending_ff, pending_in;
   logic                pending_valid_ff, pending_valid_in;
   logic [CW:0]         nf_ff, nf_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                eos_ff, eos_in;
   logic [IW-1:0]       probe_ff, probe_in;
   logic [CW-1:0]       miss_code_ff, miss_code_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [EPOCH_W-1:0]  slot_epoch;
   logic [CW-1:0]       slot_prefix;
   logic [BYTE_W-1:0]   slot_byte;
   logic [CW-1:0]       slot_code;
   logic                slot_live;
   logic                slot_match;
   logic                out_free;
   logic                room;
   logic                req_take;
   logic                rsp_load;

   function automatic logic [IW-1:0] hash_idx(input logic [CW-1:0] prefix,
                                              input logic [BYTE_W-1:0] b);
      logic [IW-1:0] p;
      logic [IW-1:0] s;
      p = IW'(prefix);
      s = IW'(b);
      return p ^ (s << (IW - BYTE_W)) ^ s;
   endfunction

   assign slot_epoch  = ram_rd_data[SLOT_W-1 -: EPOCH_W];
   assign slot_prefix = ram_rd_data[2*CW+BYTE_W-1 -: CW];
   assign slot_byte   = ram_rd_data[CW+BYTE_W-1 -: BYTE_W];
   assign slot_code   = ram_rd_data[CW-1:0];
   assign slot_live   = (slot_epoch == epoch_ff);
   assign slot_match  = slot_live && (slot_prefix == pending_ff) && (slot_byte == byte_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign room      = (nf_ff < NF_LIMIT);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);

   // table port: clear sweep, or insert on a miss while the dictionary has room
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = probe_ff;
      ram_wr_data = {epoch_ff, pending_ff, byte_ff, nf_ff[CW-1:0]};
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_LOOK && !slot_live && room) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = hash_idx(pending_ff, req_data_byte);
      end else begin
         ram_rd_addr = probe_ff + 1'b1;
      end
   end

   always_comb begin
      state_in         = state_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      nf_in            = nf_ff;
      epoch_in         = epoch_ff;
      byte_in          = byte_ff;
      eos_in           = eos_ff;
      probe_in         = probe_ff;
      miss_code_in     = miss_code_ff;
      clr_in           = clr_ff;
      rsp_load         = 1'b0;
      rsp_code_in      = rsp_code_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               byte_in = req_data_byte;
               eos_in  = req_end_of_stream;
               if (!pending_valid_ff) begin
                  pending_in       = CW'(req_data_byte);
                  pending_valid_in = 1'b1;
                  state_in         = req_end_of_stream ? ST_EMIT_LAST : ST_IDLE;
               end else begin
                  probe_in = hash_idx(pending_ff, req_data_byte);
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (slot_match) begin
               pending_in = slot_code;
               state_in   = eos_ff ? ST_EMIT_LAST : ST_IDLE;
            end else if (slot_live) begin
               probe_in = probe_ff + 1'b1;
            end else begin
               miss_code_in = pending_ff;
               pending_in   = CW'(byte_ff);
               if (room) begin
                  nf_in = nf_ff + 1'b1;
               end
               state_in = ST_EMIT_MISS;
            end
         end
         ST_EMIT_MISS: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_code_in = CODE_W'(miss_code_ff);
               rsp_last_in = 1'b0;
               state_in    = eos_ff ? ST_EMIT_LAST : ST_IDLE;
            end
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               rsp_code_in      = CODE_W'(pending_ff);
               rsp_last_in      = 1'b1;
               pending_in       = '0;
               pending_valid_in = 1'b0;
               nf_in            = NF_FIRST;
               if (epoch_ff == EPOCH_LAST) begin
                  epoch_in = EPOCH_FIRST;
                  state_in = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         nf_ff            <= NF_FIRST;
         epoch_ff         <= EPOCH_FIRST;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
         nf_ff            <= nf_in;
         epoch_ff         <= epoch_in;
         clr_ff           <= clr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      eos_ff       <= eos_in;
      probe_ff     <= probe_in;
      miss_code_ff <= miss_code_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_last_code = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      nf_ff <= NF_LIMIT && nf_ff >= NF_FIRST)
      else $error("next free code out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while held");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LAST && out_free) |=>
         (!pending_valid_ff && nf_ff == NF_FIRST && rsp_last_ff))
      else $error("stream end did not restart dictionary");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (epoch_ff != '0))
      else $error("live epoch matches cleared slots");

   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff != ST_CLEAR) |-> (state_ff == ST_LOOK && !slot_live && room))
      else $error("table write outside insert");

endmodule
